/* src/mmu_pkg.sv */
package mmu_pkg;

  localparam int ROWS_DEF  = 16;
  localparam int COLS_DEF  = 16;
  localparam int DEPTH_DEF = 16;

  localparam logic [23:0] INV_SCALE_A_RST    = 24'd65024;
  localparam logic [23:0] INV_SCALE_B_RST    = 24'd65024;
  localparam logic [31:0] COMBINED_SCALE_RST = 32'd66572;

  localparam int CODE_MAX  = 127;
  localparam int CODE_SQ   = CODE_MAX * CODE_MAX;
  localparam int RAW_W     = 19;
  localparam int RESULT_W  = 32;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] REG_INV_SCALE_A    = 2'd0;
  localparam logic [1:0] REG_INV_SCALE_B    = 2'd1;
  localparam logic [1:0] REG_COMBINED_SCALE = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD_A,
    ST_LOAD_B,
    ST_FEED,
    ST_WAIT,
    ST_MAC,
    ST_DRAIN,
    ST_READY
  } state_t;

  typedef struct packed {
    logic shift_b;
    logic mac;
    logic clear;
    logic drain;
  } cell_ctrl_t;

  // round half away from zero of |x| * inv / 2^23, clamped to 127
  function automatic logic [7:0] quantize(input logic [15:0] raw, input logic [23:0] inv);
    logic        neg;
    logic [16:0] mag;
    logic [41:0] prod;
    logic [18:0] q;
    logic [7:0]  q8;
    neg  = raw[15];
    mag  = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    prod = 42'(mag) * 42'(inv) + 42'(1 << 22);
    q    = prod[41:23];
    q8   = (q > 19'(CODE_MAX)) ? 8'(CODE_MAX) : q[7:0];
    return neg ? (8'd0 - q8) : q8;
  endfunction

endpackage

/* src/int8_quantized_matrix_multiply_unit.sv */
// Loads of A and B elements: one per cycle, no result.
// After the last B element the unit is busy: for each row and depth step COLS multiply-accumulate
// cells are fed one B code per cycle, wait, then accumulate; then each row's sums drain to memory.
// Reads: one per cycle while not busy; result strobed on done via the rd1 and rd2 registers.
// The receiver cannot stall; every result shows for exactly one cycle.
// Synchronous active-high reset clears control; result regs, code and sum memories are not cleared.
module int8_quantized_matrix_multiply_unit #(
  parameter int ROWS  = mmu_pkg::ROWS_DEF,
  parameter int COLS  = mmu_pkg::COLS_DEF,
  parameter int DEPTH = mmu_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           kind,
  input  logic signed [15:0]                   element_value,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic                                 done,
  output logic                                 valid_res,
  output logic signed [mmu_pkg::RESULT_W-1:0]  result_value,
  output logic signed [mmu_pkg::RAW_W-1:0]     raw_sum,
  output logic                                 last
);
  import mmu_pkg::*;

  localparam int A_SIZE  = ROWS * DEPTH;
  localparam int B_SIZE  = DEPTH * COLS;
  localparam int C_SIZE  = ROWS * COLS;
  localparam int MAX_AB  = (A_SIZE > B_SIZE) ? A_SIZE : B_SIZE;
  localparam int A_AW    = (A_SIZE > 1) ? $clog2(A_SIZE) : 1;
  localparam int B_AW    = (B_SIZE > 1) ? $clog2(B_SIZE) : 1;
  localparam int C_AW    = (C_SIZE > 1) ? $clog2(C_SIZE) : 1;
  localparam int LD_W    = $clog2(MAX_AB + 1);
  localparam int RD_W    = $clog2(C_SIZE + 1);
  localparam int A_CW    = $clog2(A_SIZE + 1);
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int K_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = $clog2(DEPTH * CODE_SQ + 1) + 1;
  localparam int PROD_W  = SUM_W + 32;

  logic [23:0] inv_scale_a;
  logic [23:0] inv_scale_b;
  logic [31:0] combined_scale;

  state_t state, state_next;
  cell_ctrl_t ctrl;

  logic [LD_W-1:0]  load_count;
  logic [RD_W-1:0]  read_count;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt;
  logic [K_W-1:0]   k_cnt;
  logic [A_CW-1:0]  a_base;
  logic [B_AW-1:0]  b_addr;
  logic [C_AW-1:0]  s_addr;
  logic             rd_v;

  logic accept, ld_a, ld_b, rd_acc, rd_ready, ld_a_last, ld_b_last, rd_last;
  logic col_last, k_last, row_last;

  logic [7:0]       code;
  logic [7:0]       a_rdata, b_rdata;
  logic [SUM_W-1:0] s_rdata;
  logic [A_AW-1:0]  a_raddr;
  logic             s_we;

  logic signed [7:0]       b_chain   [COLS+1];
  logic signed [SUM_W-1:0] acc_chain [COLS+1];

  assign accept    = start && !busy;
  assign ld_a      = accept && (kind == KIND_LOAD_A) && (state == ST_LOAD_A);
  assign ld_b      = accept && (kind == KIND_LOAD_B) && (state == ST_LOAD_B);
  assign rd_acc    = accept && (kind == KIND_READ);
  assign rd_ready  = rd_acc && (state == ST_READY);
  assign ld_a_last = load_count == LD_W'(A_SIZE - 1);
  assign ld_b_last = load_count == LD_W'(B_SIZE - 1);
  assign rd_last   = read_count == RD_W'(C_SIZE - 1);
  assign col_last  = col_cnt == COL_W'(COLS - 1);
  assign k_last    = k_cnt == K_W'(DEPTH - 1);
  assign row_last  = row_cnt == ROW_W'(ROWS - 1);

  assign busy = (state == ST_FEED) || (state == ST_WAIT) || (state == ST_MAC) ||
                (state == ST_DRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale_a    <= INV_SCALE_A_RST;
      inv_scale_b    <= INV_SCALE_B_RST;
      combined_scale <= COMBINED_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_SCALE_A:    inv_scale_a    <= cfg_data[23:0];
        REG_INV_SCALE_B:    inv_scale_b    <= cfg_data[23:0];
        REG_COMBINED_SCALE: combined_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD_A;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.shift_b  = rd_v;
    ctrl.mac      = 1'b0;
    ctrl.clear    = 1'b0;
    ctrl.drain    = 1'b0;
    s_we          = 1'b0;
    case (state)
      ST_LOAD_A: begin
        if (ld_a && ld_a_last) begin
          state_next = ST_LOAD_B;
        end
      end
      ST_LOAD_B: begin
        if (ld_b && ld_b_last) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        if (col_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: state_next = ST_MAC;
      ST_MAC: begin
        ctrl.mac   = 1'b1;
        ctrl.clear = (k_cnt == '0);
        state_next = k_last ? ST_DRAIN : ST_FEED;
      end
      ST_DRAIN: begin
        ctrl.drain = 1'b1;
        s_we       = 1'b1;
        if (col_last) begin
          state_next = row_last ? ST_READY : ST_FEED;
        end
      end
      ST_READY: begin
        if (rd_ready && rd_last) begin
          state_next = ST_LOAD_A;
        end
      end
      default: state_next = ST_LOAD_A;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      read_count <= '0;
      row_cnt    <= '0;
      col_cnt    <= '0;
      k_cnt      <= '0;
      a_base     <= '0;
      b_addr     <= '0;
      s_addr     <= '0;
      rd_v       <= 1'b0;
    end else begin
      rd_v <= (state == ST_FEED);
      if (ld_a) begin
        load_count <= ld_a_last ? '0 : load_count + 1'b1;
      end
      if (ld_b) begin
        load_count <= ld_b_last ? '0 : load_count + 1'b1;
        if (ld_b_last) begin
          read_count <= '0;
          row_cnt    <= '0;
          col_cnt    <= '0;
          k_cnt      <= '0;
          a_base     <= '0;
          b_addr     <= '0;
          s_addr     <= '0;
        end
      end
      if (rd_ready) begin
        read_count <= rd_last ? '0 : read_count + 1'b1;
      end
      case (state)
        ST_FEED: begin
          b_addr  <= b_addr + 1'b1;
          col_cnt <= col_last ? '0 : col_cnt + 1'b1;
        end
        ST_MAC: begin
          k_cnt <= k_last ? '0 : k_cnt + 1'b1;
        end
        ST_DRAIN: begin
          s_addr  <= s_addr + 1'b1;
          col_cnt <= col_last ? '0 : col_cnt + 1'b1;
          if (col_last) begin
            row_cnt <= row_last ? '0 : row_cnt + 1'b1;
            a_base  <= a_base + A_CW'(DEPTH);
            b_addr  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign code    = quantize(element_value, ld_b ? inv_scale_b : inv_scale_a);
  assign a_raddr = A_AW'(a_base + A_CW'(k_cnt));

  mmu_ram #(.WIDTH(8), .DEPTH(A_SIZE)) u_a_ram (
    .clk   (clk),
    .we    (ld_a),
    .waddr (load_count[A_AW-1:0]),
    .wdata (code),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmu_ram #(.WIDTH(8), .DEPTH(B_SIZE)) u_b_ram (
    .clk   (clk),
    .we    (ld_b),
    .waddr (load_count[B_AW-1:0]),
    .wdata (code),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  assign b_chain[0]   = signed'(b_rdata);
  assign acc_chain[0] = '0;

  for (genvar j = 0; j < COLS; j++) begin : g_cell
    mmu_cell #(.SUM_W(SUM_W)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .a_code  (signed'(a_rdata)),
      .b_in    (b_chain[j]),
      .b_out   (b_chain[j+1]),
      .acc_in  (acc_chain[j]),
      .acc_out (acc_chain[j+1])
    );
  end

  mmu_ram #(.WIDTH(SUM_W), .DEPTH(C_SIZE)) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_addr),
    .wdata (acc_chain[COLS]),
    .raddr (read_count[C_AW-1:0]),
    .rdata (s_rdata)
  );

  // read pipeline: sum fetch, scale multiply, round and saturate
  logic                    rd1_go, rd1_vr, rd1_last;
  logic                    rd2_go, rd2_vr, rd2_last, rd2_neg;
  logic [PROD_W-1:0]       rd2_prod;
  logic signed [RAW_W-1:0] rd2_raw;

  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic [PROD_W-1:0]       prod;
  logic signed [RAW_W-1:0] raw_sat;
  logic [PROD_W:0]         rnd_full;
  logic [63:0]             r64;
  logic [31:0]             res;

  assign sum_sel = rd1_vr ? signed'(s_rdata) : '0;
  assign sum_mag = sum_sel[SUM_W-1] ? (SUM_W'(0) - sum_sel) : sum_sel;
  assign prod    = PROD_W'(sum_mag) * PROD_W'(combined_scale);

  always_comb begin
    if (sum_sel > 262143) begin
      raw_sat = RAW_W'(262143);
    end else if (sum_sel < -262144) begin
      raw_sat = RAW_W'(-262144);
    end else begin
      raw_sat = RAW_W'(sum_sel);
    end
  end

  assign rnd_full = {1'b0, rd2_prod} + (PROD_W + 1)'(65536);
  assign r64      = 64'(rnd_full >> 17);

  always_comb begin
    if (rd2_neg) begin
      res = (r64 > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - r64[31:0]);
    end else begin
      res = (r64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r64[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd1_go <= 1'b0;
      rd2_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      rd1_go <= rd_acc;
      rd2_go <= rd1_go;
      done   <= rd2_go;
    end
  end

  always_ff @(posedge clk) begin
    rd1_vr       <= rd_ready;
    rd1_last     <= rd_ready && rd_last;
    rd2_vr       <= rd1_vr;
    rd2_last     <= rd1_last;
    rd2_neg      <= sum_sel[SUM_W-1];
    rd2_prod     <= prod;
    rd2_raw      <= raw_sat;
    valid_res    <= rd2_vr;
    last         <= rd2_last;
    raw_sum      <= rd2_raw;
    result_value <= signed'(res);
  end

`ifndef SYNTHESIS
  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && kind == KIND_READ, 3))
    else $error("result without a read transfer");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    done && last |-> valid_res)
    else $error("last flagged on an invalid result");

  a_busy_from_b: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(state == ST_LOAD_B && start && kind == KIND_LOAD_B))
    else $error("compute started without the final B transfer");

  a_mac_loaded: assert property (@(posedge clk) disable iff (rst)
    state == ST_MAC |-> !rd_v && $past(state == ST_WAIT))
    else $error("multiply-accumulate before B row fully shifted in");
`endif

endmodule

/* src/mmu_ram.sv */
module mmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mmu_cell.sv */
module mmu_cell #(
  parameter int SUM_W = 19
) (
  input  logic                    clk,
  input  mmu_pkg::cell_ctrl_t     ctrl,
  input  logic signed [7:0]       a_code,
  input  logic signed [7:0]       b_in,
  output logic signed [7:0]       b_out,
  input  logic signed [SUM_W-1:0] acc_in,
  output logic signed [SUM_W-1:0] acc_out
);
  import mmu_pkg::*;

  logic signed [7:0]       b_reg;
  logic signed [SUM_W-1:0] acc;
  logic signed [15:0]      prod;
  logic signed [SUM_W-1:0] acc_next;

  assign prod     = a_code * b_reg;
  assign acc_next = (ctrl.clear ? SUM_W'(0) : acc) + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.shift_b) begin
      b_reg <= b_in;
    end
    if (ctrl.mac) begin
      acc <= acc_next;
    end else if (ctrl.drain) begin
      acc <= acc_in;
    end
  end

  assign b_out   = b_reg;
  assign acc_out = acc;

endmodule
